@@ hw/rtl/tlcl_pkg.sv @@
// package for the two-level cache lookup block
// holds field widths, default sizes, transaction kind and status codes
// no dependencies
`default_nettype none

package tlcl_pkg;

   localparam int ADDR_W       = 8;
   localparam int DATA_W       = 8;
   localparam int CORE_W       = 2;
   localparam int CSR_W        = 9;
   localparam int CSR_IDX_W    = 1;
   localparam int ADDR_SPACE   = 256;

   localparam int L1_LINES_DEF = 64;
   localparam int L2_LINES_DEF = 128;

   localparam logic [ADDR_W-1:0] SHARED_START_RST = 8'd32;
   localparam logic [CSR_W-1:0]  SHARED_END_RST   = 9'd128;
   localparam logic [CORE_W-1:0] OWNER_ALL        = 2'b11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHARED_START = 1'b0,
      CSR_SHARED_END   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_READ     = 2'd0,
      KIND_LOAD     = 2'd1,
      KIND_FLUSH_L1 = 2'd2,
      KIND_FLUSH_L2 = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_L1_HIT = 2'd0,
      ST_L2_HIT = 2'd1,
      ST_MISS   = 2'd2,
      ST_DONE   = 2'd3
   } status_type;

   // per-address line index and tag for a cache of the given size,
   // built by counting so that any line count works
   function automatic logic [ADDR_SPACE-1:0][ADDR_W-1:0] index_table(int lines);
      logic [ADDR_SPACE-1:0][ADDR_W-1:0] tab;
      int idx;
      idx = 0;
      for (int a = 0; a < ADDR_SPACE; a++) begin
         tab[a] = ADDR_W'(idx);
         idx = idx + 1;
         if (idx == lines) begin
            idx = 0;
         end
      end
      return tab;
   endfunction

   function automatic logic [ADDR_SPACE-1:0][ADDR_W-1:0] tag_table(int lines);
      logic [ADDR_SPACE-1:0][ADDR_W-1:0] tab;
      int idx;
      int tg;
      idx = 0;
      tg  = 0;
      for (int a = 0; a < ADDR_SPACE; a++) begin
         tab[a] = ADDR_W'(tg);
         idx = idx + 1;
         if (idx == lines) begin
            idx = 0;
            tg  = tg + 1;
         end
      end
      return tab;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tlcl_ram.sv @@
// generic single-write, single-read ram with registered read data
// used for the l1 and l2 line arrays; no dependencies
`default_nettype none

module tlcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/two_level_cache_lookup.sv @@
// path: an accepted transaction is registered in the lookup stage, then in the rsp register when that stage advances
// throughput: one transaction per cycle while the response stream is not stalled; each level has
//   one ram read port with a registered read, and writebacks to a line just read are forwarded
// reset: synchronous; clears all l1/l2 valid bits at once (no clearing pass),
//   empties the pipeline, holds req_tready low and sets the shared window to [32, 128)
// depends on tlcl_pkg and tlcl_ram
`default_nettype none

module two_level_cache_lookup
   import tlcl_pkg::*;
#(
   parameter int L1_LINES = L1_LINES_DEF,
   parameter int L2_LINES = L2_LINES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   // request stream
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [23:0]          req_tdata,  // core[1:0], addr[9:2], write_data[17:10]
   input  wire logic [1:0]           req_tuser,  // kind[1:0]
   // response stream
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [7:0]           rsp_tdata,  // read_data[7:0]
   output logic      [1:0]           rsp_tuser   // status[1:0]
);

   localparam int L1_IW   = $clog2(L1_LINES);
   localparam int L2_IW   = $clog2(L2_LINES);
   localparam int L1_TMAX = (ADDR_SPACE - 1) / L1_LINES;
   localparam int L2_TMAX = (ADDR_SPACE - 1) / L2_LINES;
   localparam int L1_TW   = (L1_TMAX > 0) ? $clog2(L1_TMAX + 1) : 1;
   localparam int L2_TW   = (L2_TMAX > 0) ? $clog2(L2_TMAX + 1) : 1;
   localparam int L1_EW   = L1_TW + DATA_W;
   localparam int L2_EW   = L2_TW + CORE_W + DATA_W;

   localparam logic [ADDR_SPACE-1:0][ADDR_W-1:0] L1_IDX_TAB = index_table(L1_LINES);
   localparam logic [ADDR_SPACE-1:0][ADDR_W-1:0] L1_TAG_TAB = tag_table(L1_LINES);
   localparam logic [ADDR_SPACE-1:0][ADDR_W-1:0] L2_IDX_TAB = index_table(L2_LINES);
   localparam logic [ADDR_SPACE-1:0][ADDR_W-1:0] L2_TAG_TAB = tag_table(L2_LINES);

   // request fields
   kind_type          req_kind;
   logic [CORE_W-1:0] req_core;
   logic [ADDR_W-1:0] req_addr;
   logic [DATA_W-1:0] req_wdata;
   logic [L1_IW-1:0]  req_idx1;
   logic [L2_IW-1:0]  req_idx2;
   logic              req_fire;

   assign req_kind  = kind_type'(req_tuser);
   assign req_core  = req_tdata[1:0];
   assign req_addr  = req_tdata[9:2];
   assign req_wdata = req_tdata[17:10];
   assign req_idx1  = L1_IDX_TAB[req_addr][L1_IW-1:0];
   assign req_idx2  = L2_IDX_TAB[req_addr][L2_IW-1:0];

   // configuration
   logic [ADDR_W-1:0] shared_start_ff;
   logic [CSR_W-1:0]  shared_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_start_ff <= SHARED_START_RST;
         shared_end_ff   <= SHARED_END_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SHARED_START: shared_start_ff <= csr_wdata[ADDR_W-1:0];
            CSR_SHARED_END:   shared_end_ff   <= csr_wdata;
            default:          shared_end_ff   <= shared_end_ff;
         endcase
      end
   end

   // lookup stage registers
   logic              s1_valid_ff;
   kind_type          s1_kind_ff;
   logic [CORE_W-1:0] s1_core_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [DATA_W-1:0] s1_wdata_ff;
   logic [L1_IW-1:0]  s1_idx1_ff;
   logic [L2_IW-1:0]  s1_idx2_ff;
   logic [L1_TW-1:0]  s1_tag1_ff;
   logic [L2_TW-1:0]  s1_tag2_ff;
   logic              fwd1_ff;
   logic [L1_EW-1:0]  fwd1_ent_ff;
   logic              fwd2_ff;
   logic [L2_EW-1:0]  fwd2_ent_ff;

   logic [L1_LINES-1:0] l1_valid_ff;
   logic [L2_LINES-1:0] l2_valid_ff;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   logic s1_advance;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!s1_valid_ff || s1_advance);
   assign req_fire   = req_tvalid && req_tready;

   // line arrays
   logic             l1_we;
   logic [L1_EW-1:0] l1_wr_ent;
   logic [L1_EW-1:0] l1_rd_ent;
   logic             l2_we;
   logic [L2_EW-1:0] l2_wr_ent;
   logic [L2_EW-1:0] l2_rd_ent;

   tlcl_ram #(.WIDTH(L1_EW), .DEPTH(L1_LINES)) u_l1_ram (
      .clock   (clock),
      .wr_en   (l1_we),
      .wr_addr (s1_idx1_ff),
      .wr_data (l1_wr_ent),
      .rd_en   (req_fire),
      .rd_addr (req_idx1),
      .rd_data (l1_rd_ent)
   );

   tlcl_ram #(.WIDTH(L2_EW), .DEPTH(L2_LINES)) u_l2_ram (
      .clock   (clock),
      .wr_en   (l2_we),
      .wr_addr (s1_idx2_ff),
      .wr_data (l2_wr_ent),
      .rd_en   (req_fire),
      .rd_addr (req_idx2),
      .rd_data (l2_rd_ent)
   );

   // lookup and writeback
   logic [L1_EW-1:0]  l1_ent;
   logic [L2_EW-1:0]  l2_ent;
   logic [L1_TW-1:0]  l1_ent_tag;
   logic [DATA_W-1:0] l1_ent_byte;
   logic [L2_TW-1:0]  l2_ent_tag;
   logic [CORE_W-1:0] l2_ent_owner;
   logic [DATA_W-1:0] l2_ent_byte;
   logic              l1_hit;
   logic              l2_hit;
   logic              in_window;
   logic [CORE_W-1:0] load_owner;
   status_type        rsp_status_in;
   logic [DATA_W-1:0] rsp_data_in;
   logic              l1_fill;

   // the ram read happened while the previous transaction was writing back
   assign l1_ent = fwd1_ff ? fwd1_ent_ff : l1_rd_ent;
   assign l2_ent = fwd2_ff ? fwd2_ent_ff : l2_rd_ent;
   assign {l1_ent_tag, l1_ent_byte} = l1_ent;
   assign {l2_ent_tag, l2_ent_owner, l2_ent_byte} = l2_ent;

   assign l1_hit = l1_valid_ff[s1_idx1_ff] && (l1_ent_tag == s1_tag1_ff);
   assign l2_hit = l2_valid_ff[s1_idx2_ff] && (l2_ent_tag == s1_tag2_ff)
                   && ((l2_ent_owner & s1_core_ff) != '0);

   assign in_window  = (s1_addr_ff >= shared_start_ff)
                       && ({1'b0, s1_addr_ff} < shared_end_ff);
   assign load_owner = in_window ? OWNER_ALL : s1_core_ff;

   always_comb begin
      rsp_status_in = ST_DONE;
      rsp_data_in   = '0;
      l1_fill       = 1'b0;
      case (s1_kind_ff)
         KIND_READ: begin
            if (l1_hit) begin
               rsp_status_in = ST_L1_HIT;
               rsp_data_in   = l1_ent_byte;
            end else if (l2_hit) begin
               rsp_status_in = ST_L2_HIT;
               rsp_data_in   = l2_ent_byte;
               l1_fill       = 1'b1;
            end else begin
               rsp_status_in = ST_MISS;
            end
         end
         KIND_LOAD: begin
            l1_fill = 1'b1;
         end
         default: begin
            l1_fill = 1'b0;
         end
      endcase
   end

   assign l1_we     = s1_advance && l1_fill;
   assign l1_wr_ent = {s1_tag1_ff,
                       (s1_kind_ff == KIND_LOAD) ? s1_wdata_ff : l2_ent_byte};
   assign l2_we     = s1_advance && (s1_kind_ff == KIND_LOAD);
   assign l2_wr_ent = {s1_tag2_ff, load_owner, s1_wdata_ff};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff  <= req_kind;
         s1_core_ff  <= req_core;
         s1_addr_ff  <= req_addr;
         s1_wdata_ff <= req_wdata;
         s1_idx1_ff  <= req_idx1;
         s1_idx2_ff  <= req_idx2;
         s1_tag1_ff  <= L1_TAG_TAB[req_addr][L1_TW-1:0];
         s1_tag2_ff  <= L2_TAG_TAB[req_addr][L2_TW-1:0];
         fwd1_ff     <= l1_we && (s1_idx1_ff == req_idx1);
         fwd1_ent_ff <= l1_wr_ent;
         fwd2_ff     <= l2_we && (s1_idx2_ff == req_idx2);
         fwd2_ent_ff <= l2_wr_ent;
      end
      if (s1_advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         l1_valid_ff  <= '0;
         l2_valid_ff  <= '0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_advance && (s1_kind_ff == KIND_FLUSH_L1)) begin
            l1_valid_ff <= '0;
         end else if (l1_we) begin
            l1_valid_ff[s1_idx1_ff] <= 1'b1;
         end
         if (s1_advance && (s1_kind_ff == KIND_FLUSH_L2)) begin
            l2_valid_ff <= '0;
         end else if (l2_we) begin
            l2_valid_ff[s1_idx2_ff] <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // checks
   a_flush_l1_clears: assert property (@(posedge clock) disable iff (reset)
      s1_advance && (s1_kind_ff == KIND_FLUSH_L1) |=> (l1_valid_ff == '0))
      else $error("l1 valid bits survive a flush");

   a_flush_l2_clears: assert property (@(posedge clock) disable iff (reset)
      s1_advance && (s1_kind_ff == KIND_FLUSH_L2) |=> (l2_valid_ff == '0))
      else $error("l2 valid bits survive a flush");

   a_l2_hit_refills: assert property (@(posedge clock) disable iff (reset)
      s1_advance && (s1_kind_ff == KIND_READ) && !l1_hit && l2_hit
      |=> l1_valid_ff[$past(s1_idx1_ff)])
      else $error("l2 hit did not refill the l1 line");

   a_load_fills_both: assert property (@(posedge clock) disable iff (reset)
      s1_advance && (s1_kind_ff == KIND_LOAD)
      |=> l1_valid_ff[$past(s1_idx1_ff)] && l2_valid_ff[$past(s1_idx2_ff)])
      else $error("load did not validate both levels");

   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_advance))
      else $error("response appeared without a lookup completing");

endmodule

`default_nettype wire
